/* hdl/binary_morphology_3x3_macros.svh */
// assertion helpers, sampled on aclk and quiet while aresetn is low
`ifndef BINARY_MORPHOLOGY_3X3_MACROS_SVH
`define BINARY_MORPHOLOGY_3X3_MACROS_SVH

`define BM3_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

`define BM3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/bm3_pkg.sv */
package bm3_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_DIM_W  = 11;
    localparam int MASK_W     = 9;
    localparam int WIN        = 3;
    localparam int MIN_DIM    = 3;
    localparam int DEF_DIM    = 512;
    localparam int DEF_MASK   = 186;
    localparam int DEF_MAX_W  = 1024;
    localparam int DEF_MAX_H  = 1024;

    localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
    localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_MODE   = 2'd2,
        REG_MASK   = 2'd3
    } reg_index_t;

    typedef logic [WIN-1:0][PIX_W-1:0] column_t;

    typedef struct packed {
        logic any_set;
        logic any_clear;
    } cell_flags_t;

endpackage

/* hdl/bm3_line_buf.sv */
module bm3_line_buf #(
    parameter int DEPTH = bm3_pkg::DEF_MAX_W,
    parameter int DW    = 2 * bm3_pkg::PIX_W
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DW-1:0]            rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/bm3_cell.sv */
module bm3_cell (
    input  logic                   aclk,
    input  logic                   shift_en,
    input  bm3_pkg::column_t       col_in,
    input  logic [bm3_pkg::WIN-1:0] mask_col,
    output bm3_pkg::column_t       col_out,
    output bm3_pkg::cell_flags_t   flags
);

    bm3_pkg::column_t col_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            col_reg <= col_in;
        end
    end

    always_comb begin
        flags.any_set   = 1'b0;
        flags.any_clear = 1'b0;
        for (int k = 0; k < bm3_pkg::WIN; k++) begin
            if (mask_col[k]) begin
                if (col_reg[k] != bm3_pkg::PIX_BLACK) begin
                    flags.any_set = 1'b1;
                end else begin
                    flags.any_clear = 1'b1;
                end
            end
        end
    end

    assign col_out = col_reg;

endmodule

/* hdl/binary_morphology_3x3.sv */
// a result passes the line buffer, filter and output registers; the request completing
//   it trails its own pixel by image_width+1 requests (drain requests flush the tail)
// throughput: one request per cycle while the skid is empty, set by the line buffer with
//   one read and one write port and the three-cell window chain shifting once per request
// reset: synchronous active-low aresetn clears counters, valids and config registers;
//   the line buffer is not cleared and needs no clearing pass
module binary_morphology_3x3 #(
    parameter int MAX_WIDTH  = bm3_pkg::DEF_MAX_W,
    parameter int MAX_HEIGHT = bm3_pkg::DEF_MAX_H
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [bm3_pkg::CFG_DIM_W-1:0] cfg_data,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] pixel
    input  logic                          s_tuser,   // [0] drain
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] out_pixel
    output logic                          m_tlast    // last_of_frame
);

    localparam int PW  = bm3_pkg::PIX_W;
    localparam int WIN = bm3_pkg::WIN;
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int FW  = $clog2(MAX_WIDTH + 1);
    localparam int FH  = $clog2(MAX_HEIGHT + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int TW  = FW + FH;
    localparam int QW  = $clog2(MAX_WIDTH * MAX_HEIGHT);

    function automatic logic [31:0] clamp_dim(input logic [31:0] v, input logic [31:0] hi);
        logic [31:0] r;
        r = v;
        if (v < 32'(bm3_pkg::MIN_DIM)) begin
            r = 32'(bm3_pkg::MIN_DIM);
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    // configuration registers
    logic [bm3_pkg::CFG_DIM_W-1:0] width_reg, height_reg;
    logic                          mode_reg;
    logic [bm3_pkg::MASK_W-1:0]    mask_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= bm3_pkg::CFG_DIM_W'(bm3_pkg::DEF_DIM);
            height_reg <= bm3_pkg::CFG_DIM_W'(bm3_pkg::DEF_DIM);
            mode_reg   <= 1'b0;
            mask_reg   <= bm3_pkg::MASK_W'(bm3_pkg::DEF_MASK);
        end else if (cfg_valid && cfg_ready) begin
            case (bm3_pkg::reg_index_t'(cfg_index))
                bm3_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                bm3_pkg::REG_HEIGHT: height_reg <= cfg_data;
                bm3_pkg::REG_MODE:   mode_reg   <= cfg_data[0];
                bm3_pkg::REG_MASK:   mask_reg   <= cfg_data[bm3_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic adv;
    logic out_valid_reg, skid_valid_reg;
    logic [PW-1:0] out_data_reg, skid_data_reg;
    logic out_last_reg, skid_last_reg;

    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    // accept stage: raster counters
    logic [AW-1:0] in_col_reg, in_col_next;
    logic [RW-1:0] in_row_reg, in_row_next;
    logic [QW-1:0] pos_reg, pos_next;
    logic [FW-1:0] fw_reg, fw_cur;
    logic [FH-1:0] fh_reg, fh_cur;
    logic [TW-1:0] total_reg;

    logic accept, at_start, flushing, ignore, emit, interior, last;
    logic [31:0] c32, r32, fw32, fh32;
    logic [PW-1:0] pix_in;

    assign accept   = s_tvalid && s_tready;
    assign at_start = (in_col_reg == '0) && (in_row_reg == '0);

    always_comb begin
        fw_cur = fw_reg;
        fh_cur = fh_reg;
        if (at_start) begin
            fw_cur = FW'(clamp_dim(32'(width_reg), 32'(MAX_WIDTH)));
            fh_cur = FH'(clamp_dim(32'(height_reg), 32'(MAX_HEIGHT)));
        end
        c32  = 32'(in_col_reg);
        r32  = 32'(in_row_reg);
        fw32 = 32'(fw_cur);
        fh32 = 32'(fh_cur);

        flushing = r32 >= fh32;
        ignore   = !flushing && s_tuser;
        pix_in   = flushing ? bm3_pkg::PIX_BLACK : s_tdata;
        emit     = (c32 >= 32'd1 && r32 >= 32'd1) || (c32 == 32'd0 && r32 >= 32'd2);
        interior = (c32 >= 32'd2) && (c32 + 32'd1 <= fw32)
                && (r32 >= 32'd2) && (r32 + 32'd1 <= fh32);
        last     = emit && (32'(pos_reg) + 32'd1 >= 32'(total_reg));

        if (c32 + 32'd1 >= fw32) begin
            in_col_next = '0;
            in_row_next = in_row_reg + RW'(1);
        end else begin
            in_col_next = in_col_reg + AW'(1);
            in_row_next = in_row_reg;
        end
        pos_next = emit ? pos_reg + QW'(1) : pos_reg;
        // frame end returns everything to the start
        if (last) begin
            in_col_next = '0;
            in_row_next = '0;
            pos_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            pos_reg    <= '0;
            fw_reg     <= FW'(clamp_dim(32'(bm3_pkg::DEF_DIM), 32'(MAX_WIDTH)));
            fh_reg     <= FH'(clamp_dim(32'(bm3_pkg::DEF_DIM), 32'(MAX_HEIGHT)));
        end else if (accept) begin
            fw_reg <= fw_cur;
            fh_reg <= fh_cur;
            if (!ignore) begin
                in_col_reg <= in_col_next;
                in_row_reg <= in_row_next;
                pos_reg    <= pos_next;
            end
        end
    end

    // needed only at frame end, long after the dims settle
    always_ff @(posedge aclk) begin
        total_reg <= TW'(fw_reg) * TW'(fh_reg);
    end

    // line buffer stage
    logic          b_valid_reg, b_emit_reg, b_interior_reg, b_last_reg;
    logic [AW-1:0] b_addr_reg;
    logic [PW-1:0] b_pix_reg;
    logic [2*PW-1:0] lb_rd_data;
    logic [PW-1:0] up_q, lo_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= accept && !ignore;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_emit_reg     <= emit;
            b_interior_reg <= interior;
            b_last_reg     <= last;
            b_addr_reg     <= in_col_reg;
            b_pix_reg      <= pix_in;
        end
    end

    bm3_line_buf #(
        .DEPTH (MAX_WIDTH),
        .DW    (2 * PW)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (adv),
        .rd_addr (in_col_reg),
        .rd_data (lb_rd_data),
        .wr_en   (adv && b_valid_reg),
        .wr_addr (b_addr_reg),
        .wr_data ({lo_q, b_pix_reg})
    );

    // upper row in the high half, lower row in the low half
    assign up_q = lb_rd_data[2*PW-1:PW];
    assign lo_q = lb_rd_data[PW-1:0];

    // window chain: cell 2 takes the new column, cell 0 holds the oldest
    bm3_pkg::column_t    win_col [WIN];
    bm3_pkg::column_t    chain_in [WIN];
    bm3_pkg::cell_flags_t cell_flags [WIN];

    for (genvar j = 0; j < WIN; j++) begin : g_cell
        if (j == WIN - 1) begin : g_head
            assign chain_in[j] = {b_pix_reg, lo_q, up_q};
        end else begin : g_link
            assign chain_in[j] = win_col[j+1];
        end
        bm3_cell u_cell (
            .aclk     (aclk),
            .shift_en (adv && b_valid_reg),
            .col_in   (chain_in[j]),
            .mask_col ({mask_reg[2*WIN+j], mask_reg[WIN+j], mask_reg[j]}),
            .col_out  (win_col[j]),
            .flags    (cell_flags[j])
        );
    end

    // filter stage
    logic c_valid_reg, c_interior_reg, c_last_reg;
    logic any_set, any_clear, res_valid;
    logic [PW-1:0] res_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_valid_reg && b_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_interior_reg <= b_interior_reg;
            c_last_reg     <= b_last_reg;
        end
    end

    always_comb begin
        any_set   = 1'b0;
        any_clear = 1'b0;
        for (int j = 0; j < WIN; j++) begin
            any_set   = any_set   | cell_flags[j].any_set;
            any_clear = any_clear | cell_flags[j].any_clear;
        end
        // border pixels take the window center, which also covers the row-start edge copy
        if (!c_interior_reg) begin
            res_data = win_col[1][1];
        end else if (!mode_reg) begin
            res_data = any_set ? bm3_pkg::PIX_WHITE : bm3_pkg::PIX_BLACK;
        end else begin
            res_data = any_clear ? bm3_pkg::PIX_BLACK : bm3_pkg::PIX_WHITE;
        end
    end

    assign res_valid = c_valid_reg && adv;

    // output register with skid slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && !m_tready) begin
            if (res_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_valid_reg && !m_tready) begin
            if (res_valid) begin
                skid_data_reg <= res_data;
                skid_last_reg <= c_last_reg;
            end
        end else if (skid_valid_reg) begin
            out_data_reg <= skid_data_reg;
            out_last_reg <= skid_last_reg;
        end else begin
            out_data_reg <= res_data;
            out_last_reg <= c_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`include "binary_morphology_3x3_macros.svh"

    `BM3_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_reg || out_valid_reg, "skid without output")
    `BM3_ASSERT_ALWAYS(a_col_in_frame, 32'(in_col_reg) < 32'(fw_reg), "column past frame width")
    `BM3_ASSERT_ALWAYS(a_row_in_flush, 32'(in_row_reg) <= 32'(fh_reg) + 32'd1, "row past flush")
    `BM3_ASSERT_NEXT(a_skid_kept, skid_valid_reg && !m_tready, skid_valid_reg, "skid dropped")

endmodule

/* test/morph_checker.sv */
`timescale 1ns / 100ps

module morph_checker #(
    parameter int MAX_W = bm3_pkg::DEF_MAX_W,
    parameter int MAX_H = bm3_pkg::DEF_MAX_H
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [bm3_pkg::CFG_DIM_W-1:0] cfg_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] pixel
    input  logic                          s_tuser,   // [0] drain
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [7:0]                    m_tdata,   // [7:0] out_pixel
    input  logic                          m_tlast,   // last_of_frame
    output int                            fail_count,
    output int                            pending,
    output int                            checked
);
    import bm3_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } filtered_pixel_t;

    filtered_pixel_t filtered_q[$];

    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    logic                 mode_reg;
    logic [MASK_W-1:0]    mask_reg;

    // two_up holds the row two above the incoming one, one_up the row just above
    logic [PIX_W-1:0] two_up [MAX_W];
    logic [PIX_W-1:0] one_up [MAX_W];
    logic [PIX_W-1:0] win [WIN][WIN];
    int col_in, row_in, out_pos, frame_w, frame_h;

    function automatic int clamp_dim(input int v, input int hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] morph_window();
        logic any_set, any_clear;
        int k;
        any_set = 1'b0;
        any_clear = 1'b0;
        for (k = 0; k < WIN * WIN; k++) begin
            if (mask_reg[k]) begin
                if (win[k / WIN][k % WIN] != '0) any_set = 1'b1;
                else any_clear = 1'b1;
            end
        end
        if (!mode_reg) return any_set ? PIX_WHITE : PIX_BLACK;
        return any_clear ? PIX_BLACK : PIX_WHITE;
    endfunction

    function automatic bit predict_pixel(input logic [PIX_W-1:0] pix_in, input logic drain_in,
                                         output filtered_pixel_t res);
        int c, r, k;
        logic [PIX_W-1:0] pix, above2, above1, wrap_px;
        bit emit;
        emit = 1'b0;
        res = '0;
        // geometry is latched on the first request of each frame
        if (row_in == 0 && col_in == 0) begin
            frame_w = clamp_dim(int'(width_reg), MAX_W);
            frame_h = clamp_dim(int'(height_reg), MAX_H);
        end
        if (row_in < frame_h && drain_in) return 1'b0;
        pix = (row_in >= frame_h) ? '0 : pix_in;
        c = col_in;
        r = row_in;
        above2 = two_up[c];
        above1 = one_up[c];
        wrap_px = two_up[frame_w - 1];
        for (k = 0; k < WIN; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = above2;
        win[1][2] = above1;
        win[2][2] = pix;
        two_up[c] = above1;
        one_up[c] = pix;
        if (c >= 1 && r >= 1) begin
            if (r >= 2 && r + 1 <= frame_h && c >= 2 && c + 1 <= frame_w)
                res.pixel = morph_window();
            else
                res.pixel = win[1][1];
            emit = 1'b1;
        end else if (c == 0 && r >= 2) begin
            // last column of the previous output row
            res.pixel = wrap_px;
            emit = 1'b1;
        end
        c++;
        if (c >= frame_w) begin
            c = 0;
            r++;
        end
        col_in = c;
        row_in = r;
        if (emit) begin
            if (out_pos + 1 >= frame_w * frame_h) begin
                res.last = 1'b1;
                col_in = 0;
                row_in = 0;
                out_pos = 0;
            end else begin
                out_pos++;
            end
        end
        return emit;
    endfunction

    always @(posedge aclk) begin : monitor
        filtered_pixel_t want;
        int i, j;
        if (!aresetn) begin
            width_reg = CFG_DIM_W'(DEF_DIM);
            height_reg = CFG_DIM_W'(DEF_DIM);
            mode_reg = 1'b0;
            mask_reg = MASK_W'(DEF_MASK);
            col_in = 0;
            row_in = 0;
            out_pos = 0;
            frame_w = DEF_DIM;
            frame_h = DEF_DIM;
            for (i = 0; i < MAX_W; i++) begin
                two_up[i] = '0;
                one_up[i] = '0;
            end
            for (i = 0; i < WIN; i++)
                for (j = 0; j < WIN; j++)
                    win[i][j] = '0;
            filtered_q.delete();
            fail_count = 0;
            checked = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (reg_index_t'(cfg_index))
                    REG_WIDTH:  width_reg = cfg_data;
                    REG_HEIGHT: height_reg = cfg_data;
                    REG_MODE:   mode_reg = cfg_data[0];
                    REG_MASK:   mask_reg = cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (predict_pixel(s_tdata, s_tuser, want)) filtered_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                if (filtered_q.size() == 0) begin
                    $display("%0t: result %0d (last %0b) with nothing expected",
                             $time, m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    want = filtered_q.pop_front();
                    checked++;
                    if (m_tdata !== want.pixel) begin
                        $display("%0t: out_pixel mismatch, expected %0d, actual %0d",
                                 $time, want.pixel, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: last_of_frame mismatch, expected %0b, actual %0b",
                                 $time, want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        pending <= filtered_q.size();
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import bm3_pkg::*;

    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int RANDOM_ITEMS  = 500;
    localparam int SMALL_AREA    = 600;
    // first directed frame, pixel 0 in the low byte
    localparam logic [8*9-1:0] FIRST_FRAME =
        {8'h55, 8'h00, 8'hFE, 8'h7F, 8'h00, 8'h80, 8'h01, 8'hFF, 8'h00};

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    reg_index_t           cfg_index = REG_WIDTH;
    logic [CFG_DIM_W-1:0] cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;
    logic                 m_tlast;

    int fail_count;
    int pending;
    int checked;

    int  reg_w = DEF_DIM;
    int  reg_h = DEF_DIM;
    int  frames = 0;
    int  requests = 0;
    int  ignored = 0;
    bit  src_calm = 1'b0;
    bit  sink_calm = 1'b0;
    int  stall_left = 0;
    int  idle_cycles = 0;

    binary_morphology_3x3 i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    morph_checker i_checker (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int eff_dim(input int v, input int hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int pick_gap(input bit calm);
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int small_dim();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return $urandom_range(0, 2);
        if (roll < 5) return $urandom_range(9, 24);
        return $urandom_range(3, 8);
    endfunction

    function automatic int random_mask();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 0;
        if (roll == 1) return (1 << MASK_W) - 1;
        return $urandom_range(0, (1 << MASK_W) - 1);
    endfunction

    function automatic logic [7:0] random_pixel(input int density);
        if ($urandom_range(0, 99) < density) return 8'($urandom_range(1, 255));
        return 8'h00;
    endfunction

    task automatic send_request(input logic [7:0] pix, input logic drain);
        int gap;
        gap = pick_gap(src_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= drain;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        requests++;
    endtask

    // hold the source until every predicted result is out, then let the pipe settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DIM_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
        if (idx == REG_WIDTH) reg_w = int'(value[CFG_DIM_W-1:0]);
        if (idx == REG_HEIGHT) reg_h = int'(value[CFG_DIM_W-1:0]);
    endtask

    task automatic run_frame(input int density, input bit noisy, input bit retune);
        int w, h, n, retune_at;
        w = eff_dim(reg_w, DEF_MAX_W);
        h = eff_dim(reg_h, DEF_MAX_H);
        src_calm = ($urandom_range(0, 3) == 0);
        retune_at = retune ? $urandom_range(1, w * h - 1) : -1;
        for (n = 0; n < w * h; n++) begin
            // mode and mask apply at once, a new width only from the next frame
            if (n == retune_at) begin
                wait_drained();
                write_reg(REG_MODE, $urandom_range(0, 1));
                write_reg(REG_MASK, random_mask());
                if ($urandom_range(0, 1)) write_reg(REG_WIDTH, small_dim());
            end
            if (noisy && $urandom_range(0, 9) == 0) begin
                send_request(8'($urandom_range(0, 255)), 1'b1);
                ignored++;
            end
            send_request(random_pixel(density), 1'b0);
        end
        // flush: a pixel here counts as a drain tick
        for (n = 0; n <= w; n++) begin
            if ($urandom_range(0, 2) == 0) send_request(8'($urandom_range(0, 255)), 1'b0);
            else send_request(8'($urandom_range(0, 255)), 1'b1);
        end
        frames++;
    endtask

    initial begin : sink
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap(sink_calm);
            end
            if ($urandom_range(0, 299) == 0) sink_calm = !sink_calm;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        int i, rand_base, density;
        bit force_dims;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: 3x3 frame under the reset mode and cross mask, with extreme values,
        // a drain before the first pixel and one mid-frame, and a pixel during the flush
        write_reg(REG_WIDTH, MIN_DIM);
        write_reg(REG_HEIGHT, MIN_DIM);
        send_request(8'hA5, 1'b1);
        ignored++;
        for (i = 0; i < 9; i++) begin
            if (i == 4) begin
                send_request(8'hFF, 1'b1);
                ignored++;
            end
            send_request(FIRST_FRAME[8*i +: 8], 1'b0);
        end
        send_request(8'hAA, 1'b0);
        for (i = 0; i < MIN_DIM; i++) send_request(8'h00, 1'b1);
        frames++;

        // directed: empty mask in erode mode on an all-clear frame
        wait_drained();
        write_reg(REG_MODE, 1);
        write_reg(REG_MASK, 0);
        for (i = 0; i < 9; i++) send_request(8'h00, 1'b0);
        for (i = 0; i <= MIN_DIM; i++) send_request(8'hFF, 1'b1);
        frames++;

        // random frames of small geometry, a few with clamped dimensions
        rand_base = requests - ignored;
        while (requests - ignored - rand_base < RANDOM_ITEMS) begin
            force_dims = eff_dim(reg_w, DEF_MAX_W) * eff_dim(reg_h, DEF_MAX_H) > SMALL_AREA;
            if (force_dims || $urandom_range(0, 9) < 6) begin
                wait_drained();
                if (force_dims || $urandom_range(0, 1)) write_reg(REG_WIDTH, small_dim());
                if (force_dims || $urandom_range(0, 1)) write_reg(REG_HEIGHT, small_dim());
                if ($urandom_range(0, 1)) write_reg(REG_MODE, $urandom_range(0, 1));
                if ($urandom_range(0, 1)) write_reg(REG_MASK, random_mask());
            end
            case ($urandom_range(0, 4))
                0:       density = 0;
                1:       density = 10;
                2:       density = 50;
                3:       density = 90;
                default: density = 100;
            endcase
            run_frame(density, $urandom_range(0, 9) < 3, $urandom_range(0, 99) < 15);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        $display("run covered %0d frames, %0d requests (%0d ignored drains), %0d results checked",
                 frames, requests, ignored, checked);
        $display("geometry from 3x3 up to 24 wide or high incl. clamped small values, both modes");
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
